// ----- hw/rtl/erase_range_planner_core_macros.svh -----
// Assertion macros shared by the erase range planner checker.
`ifndef ERASE_RANGE_PLANNER_CORE_MACROS_SVH
`define ERASE_RANGE_PLANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/erp_pkg.sv -----
// Shared widths, codes and types of the erase range planner.
`default_nettype none

package erp_pkg;

    // Field and datapath widths.
    localparam int UnitW      = 25;
    localparam int DevW       = 32;
    localparam int AddrFieldW = 32;
    localparam int PosW       = 33;
    localparam int StatusW    = 3;
    localparam int OpW        = 8;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 32;

    // The remainder unit walks one dividend bit per cycle.
    localparam int ModSteps   = PosW;
    localparam int ModCntW    = $clog2(ModSteps + 1);

    typedef logic [StatusW-1:0] t_status;
    typedef logic [OpW-1:0]     t_opcode;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // Result status codes.
    localparam t_status ST_CMD    = 3'd0;
    localparam t_status ST_ACCEPT = 3'd1;
    localparam t_status ST_EMPTY  = 3'd2;
    localparam t_status ST_ERROR  = 3'd3;
    localparam t_status ST_IDLE   = 3'd4;

    // Erase command bytes.
    localparam t_opcode OP_NONE   = 8'h00;
    localparam t_opcode OP_SECTOR = 8'h20;
    localparam t_opcode OP_BLOCK  = 8'hD8;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_SECTOR = 2'd0;
    localparam t_cfg_idx CFG_BLOCK  = 2'd1;
    localparam t_cfg_idx CFG_DEVICE = 2'd2;

    // Register values after reset.
    localparam logic [UnitW-1:0] SEC_RESET = 25'd4096;
    localparam logic [UnitW-1:0] BLK_RESET = 25'd65536;
    localparam logic [DevW-1:0]  DEV_RESET = 32'd16777216;

    // Effective configuration as seen by the sequencer.
    typedef struct packed {
        logic [UnitW-1:0] sec_unit;
        logic [UnitW-1:0] blk_unit;
        logic [DevW-1:0]  dev_bytes;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/erase_range_planner_core.sv -----
// Erase range planner: range check, sector alignment and erase command walk.
// A start request runs the bit-serial remainder unit twice (end and start address) and
// a next request once, each run 33 steps; an empty, rejected or idle request skips it.
// One request is in work at a time; the output register lets the next be taken in the
// cycle after a result is loaded.
// Synchronous active-low reset restores the default sizes and clears any plan.
`default_nettype none

module erase_range_planner_core #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire erp_pkg::t_cfg_idx             i_cfg_idx,
    input  wire logic [erp_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_kind,
    input  wire logic [erp_pkg::AddrFieldW-1:0] i_start_addr,
    input  wire logic [erp_pkg::AddrFieldW-1:0] i_length,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output erp_pkg::t_status                   o_status,
    output erp_pkg::t_opcode                   o_erase_opcode,
    output logic [erp_pkg::AddrFieldW-1:0]     o_erase_addr,
    output logic                               o_last
);
    import erp_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_END_GO   = 4'd2;
    localparam logic [3:0] S_MOD_END  = 4'd3;
    localparam logic [3:0] S_ROUND    = 4'd4;
    localparam logic [3:0] S_CAP      = 4'd5;
    localparam logic [3:0] S_MOD_ADDR = 4'd6;
    localparam logic [3:0] S_ACCEPT   = 4'd7;
    localparam logic [3:0] S_NEXT_CHK = 4'd8;
    localparam logic [3:0] S_MOD_CUR  = 4'd9;
    localparam logic [3:0] S_STEP     = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    t_cfg w_cfg;

    logic                   w_mod_start;
    logic [PosW-1:0]        w_mod_dvd;
    logic [UnitW-1:0]       w_mod_div;
    logic                   w_mod_done;
    logic [UnitW-1:0]       w_mod_rem;

    logic [3:0]             r_state,   n_state;
    logic                   r_pending, n_pending;
    logic [PosW-1:0]        r_cursor,  n_cursor;
    logic [PosW-1:0]        r_end,     n_end;
    logic [AddrFieldW-1:0]  r_addr,    n_addr;
    logic [AddrFieldW-1:0]  r_len,     n_len;
    logic                   r_rem_hit, n_rem_hit;
    logic [UnitW-1:0]       r_pad,     n_pad;
    logic                   r_blk_hit, n_blk_hit;
    logic [PosW-1:0]        r_at,      n_at;
    t_status                r_res_status, n_res_status;
    t_opcode                r_res_op,     n_res_op;
    logic                   r_res_last,   n_res_last;

    logic                   r_out_valid,  n_out_valid;
    t_status                r_out_status, n_out_status;
    t_opcode                r_out_op,     n_out_op;
    logic [ADDR_WIDTH-1:0]  r_out_addr,   n_out_addr;
    logic                   r_out_last,   n_out_last;

    logic [AddrFieldW-1:0]  w_room;
    logic [PosW-1:0]        w_left;

    erp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    erp_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_mod_div),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign o_in_ready = (r_state == S_IDLE);

    // Space left in the device past the start, and bytes left in the plan.
    assign w_room = w_cfg.dev_bytes - r_addr;
    assign w_left = r_end - r_cursor;

    // The cursor walk divides by the block size, range setup by the sector size.
    assign w_mod_div = (r_state == S_NEXT_CHK || r_state == S_MOD_CUR) ?
                       w_cfg.blk_unit : w_cfg.sec_unit;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_pending    = r_pending;
        n_cursor     = r_cursor;
        n_end        = r_end;
        n_addr       = r_addr;
        n_len        = r_len;
        n_rem_hit    = r_rem_hit;
        n_pad        = r_pad;
        n_blk_hit    = r_blk_hit;
        n_at         = r_at;
        n_res_status = r_res_status;
        n_res_op     = r_res_op;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_op     = r_out_op;
        n_out_addr   = r_out_addr;
        n_out_last   = r_out_last;
        w_mod_start  = 1'b0;
        w_mod_dvd    = r_cursor;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_addr  = i_start_addr;
                    n_len   = i_length;
                    n_state = i_kind ? S_NEXT_CHK : S_CHECK;
                end
            end
            // Any start drops the pending plan; reject empty or oversized ranges.
            S_CHECK: begin
                n_pending  = 1'b0;
                n_res_op   = OP_NONE;
                n_res_last = 1'b0;
                if (r_len == '0) begin
                    n_res_status = ST_EMPTY;
                    n_state      = S_DONE;
                end else if (r_addr >= w_cfg.dev_bytes || r_len > w_room) begin
                    n_res_status = ST_ERROR;
                    n_state      = S_DONE;
                end else begin
                    n_end   = {1'b0, r_addr} + {1'b0, r_len};
                    n_state = S_END_GO;
                end
            end
            S_END_GO: begin
                w_mod_start = 1'b1;
                w_mod_dvd   = r_end;
                n_state     = S_MOD_END;
            end
            S_MOD_END: begin
                if (w_mod_done) begin
                    n_rem_hit = (w_mod_rem != '0);
                    n_pad     = w_cfg.sec_unit - w_mod_rem;
                    n_state   = S_ROUND;
                end
            end
            // Round the end up to a sector boundary.
            S_ROUND: begin
                if (r_rem_hit) begin
                    n_end = r_end + PosW'(r_pad);
                end
                n_state = S_CAP;
            end
            // Cap the end at the device size and align the start down.
            S_CAP: begin
                if (r_end > PosW'(w_cfg.dev_bytes)) begin
                    n_end = PosW'(w_cfg.dev_bytes);
                end
                w_mod_start = 1'b1;
                w_mod_dvd   = PosW'(r_addr);
                n_state     = S_MOD_ADDR;
            end
            S_MOD_ADDR: begin
                if (w_mod_done) begin
                    n_cursor = PosW'(r_addr) - PosW'(w_mod_rem);
                    n_state  = S_ACCEPT;
                end
            end
            S_ACCEPT: begin
                n_pending    = (r_cursor < r_end);
                n_res_status = ST_ACCEPT;
                n_state      = S_DONE;
            end
            // A next request with no plan left reports idle.
            S_NEXT_CHK: begin
                n_res_op   = OP_NONE;
                n_res_last = 1'b0;
                if (!r_pending || r_cursor >= r_end) begin
                    n_pending    = 1'b0;
                    n_res_status = ST_IDLE;
                    n_state      = S_DONE;
                end else begin
                    w_mod_start = 1'b1;
                    w_mod_dvd   = r_cursor;
                    n_state     = S_MOD_CUR;
                end
            end
            // Block erase only at a block boundary with a whole block left.
            S_MOD_CUR: begin
                if (w_mod_done) begin
                    n_blk_hit = (w_mod_rem == '0) && (w_left >= PosW'(w_cfg.blk_unit));
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                n_at     = r_cursor;
                n_cursor = r_cursor + PosW'(r_blk_hit ? w_cfg.blk_unit : w_cfg.sec_unit);
                n_state  = S_FIN;
            end
            // The command is last when the cursor reaches the end or wraps.
            S_FIN: begin
                n_res_last   = (r_cursor >= r_end) || (r_cursor <= r_at);
                n_pending    = !n_res_last;
                n_res_status = ST_CMD;
                n_res_op     = r_blk_hit ? OP_BLOCK : OP_SECTOR;
                n_state      = S_DONE;
            end
            // Hand the result over once the output register is free.
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_op     = r_res_op;
                    n_out_last   = r_res_last;
                    n_out_addr   = (r_res_status == ST_CMD) ? r_at[ADDR_WIDTH-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and plan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_cursor    <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_cursor    <= n_cursor;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_rem_hit    <= n_rem_hit;
        r_pad        <= n_pad;
        r_blk_hit    <= n_blk_hit;
        r_at         <= n_at;
        r_res_status <= n_res_status;
        r_res_op     <= n_res_op;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_op     <= n_out_op;
        r_out_addr   <= n_out_addr;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_erase_opcode = r_out_op;
    assign o_erase_addr   = AddrFieldW'(r_out_addr);
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/erp_cfg.sv -----
// Configuration register file with zero-size unit mapping.
`default_nettype none

module erp_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire erp_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [erp_pkg::CfgDataW-1:0] i_cfg_data,
    output erp_pkg::t_cfg          o_cfg
);
    import erp_pkg::*;

    logic [UnitW-1:0] r_sec;
    logic [UnitW-1:0] r_blk;
    logic [DevW-1:0]  r_dev;

    // Register writes; an unknown index leaves everything as it is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= SEC_RESET;
            r_blk <= BLK_RESET;
            r_dev <= DEV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SECTOR: r_sec <= i_cfg_data[UnitW-1:0];
                CFG_BLOCK:  r_blk <= i_cfg_data[UnitW-1:0];
                CFG_DEVICE: r_dev <= i_cfg_data[DevW-1:0];
                default: ;
            endcase
        end
    end

    // A unit size of zero behaves as one byte.
    assign o_cfg.sec_unit  = (r_sec == '0) ? UnitW'(1) : r_sec;
    assign o_cfg.blk_unit  = (r_blk == '0) ? UnitW'(1) : r_blk;
    assign o_cfg.dev_bytes = r_dev;

endmodule

`default_nettype wire

// ----- hw/rtl/erp_mod_unit.sv -----
// Bit-serial remainder unit: one restoring step per cycle.
`default_nettype none

module erp_mod_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [erp_pkg::PosW-1:0]   i_dividend,
    input  wire logic [erp_pkg::UnitW-1:0]  i_divisor,
    output logic                            o_done,
    output logic [erp_pkg::UnitW-1:0]       o_rem
);
    import erp_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [ModCntW-1:0] r_cnt;
    logic [PosW-1:0]    r_dvd;
    logic [UnitW-1:0]   r_rem;

    logic [UnitW:0]     w_trial;
    logic [UnitW:0]     w_diff;
    logic [UnitW-1:0]   n_rem;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[PosW-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = w_diff[UnitW-1:0];
        end else begin
            n_rem = w_trial[UnitW-1:0];
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ModCntW'(ModSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - ModCntW'(1);
                if (r_cnt == ModCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifter and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PosW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- hw/rtl/erp_checker.sv -----
// Port-level checker for the erase range planner, bound to the top level.
`default_nettype none
`include "erase_range_planner_core_macros.svh"

module erp_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            i_in_rdy,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_rdy,
    input wire erp_pkg::t_status                i_status,
    input wire erp_pkg::t_opcode                i_opcode,
    input wire logic [erp_pkg::AddrFieldW-1:0]  i_addr,
    input wire logic                            i_last
);
    import erp_pkg::*;

    // A result stays offered until it is taken.
    `ERP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_rdy, i_out_valid, "result dropped before it was taken")

    // A stalled result keeps its payload.
    `ERP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_rdy, $stable(i_status) && $stable(i_opcode) && $stable(i_addr) && $stable(i_last), "stalled result changed")

    // The block works on one request at a time.
    `ERP_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_rdy, !i_in_rdy, "request taken while another is in work")

    // Only an issued command carries an opcode, an address or a last mark.
    `ERP_ASSERT_NOW(a_no_cmd_fields, i_clk, i_rst_n, $past(i_rst_n) && i_out_valid && i_status != ST_CMD, i_opcode == OP_NONE && i_addr == '0 && !i_last, "non-command result carries command fields")

    // An issued command is a sector or a block erase.
    `ERP_ASSERT_NOW(a_cmd_opcode, i_clk, i_rst_n, $past(i_rst_n) && i_out_valid && i_status == ST_CMD, i_opcode == OP_SECTOR || i_opcode == OP_BLOCK, "command with an unknown opcode")

endmodule

bind erase_range_planner_core erp_checker u_erp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_rdy    (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_rdy   (i_out_ready),
    .i_status    (o_status),
    .i_opcode    (o_erase_opcode),
    .i_addr      (o_erase_addr),
    .i_last      (o_last)
);

`default_nettype wire

// ----- tb/erp_tb_pkg.sv -----
// Request kinds and the spare register index used across the planner testbench.
package erp_tb_pkg;

    // Request kinds carried in the kind field.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    // Register index with no register behind it; writes to it must be dropped.
    localparam erp_pkg::t_cfg_idx CFG_UNUSED = 2'd3;

endpackage

// ----- tb/erase_plan_checker.sv -----
// Checker that predicts the planner's result for each request and compares it.
module erase_plan_checker #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  erp_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [erp_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_kind,
    input  logic [erp_pkg::AddrFieldW-1:0] i_start_addr,
    input  logic [erp_pkg::AddrFieldW-1:0] i_length,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  erp_pkg::t_status               i_status,
    input  erp_pkg::t_opcode               i_erase_opcode,
    input  logic [erp_pkg::AddrFieldW-1:0] i_erase_addr,
    input  logic                           i_last,
    output int                             o_open_count,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import erp_pkg::*;
    import erp_tb_pkg::*;

    typedef struct packed {
        t_status               status;
        t_opcode               opcode;
        logic [AddrFieldW-1:0] addr;
        logic                  last;
    } t_erase_result;

    // Results still owed by the planner, oldest first.
    t_erase_result planned_results[$];

    // Shadow of the size registers and of the erase walk.
    logic [UnitW-1:0] sec_size;
    logic [UnitW-1:0] blk_size;
    logic [DevW-1:0]  dev_size;
    logic [PosW-1:0]  walk_pos;
    logic [PosW-1:0]  walk_end;
    logic             plan_live;

    // Works out the result of one request and advances the walk.
    function automatic t_erase_result plan_next_result(input logic kind,
                                                       input logic [AddrFieldW-1:0] first,
                                                       input logic [AddrFieldW-1:0] span);
        t_erase_result res;
        logic [63:0]   sec;
        logic [63:0]   blk;
        logic [63:0]   dev;
        logic [63:0]   base;
        logic [63:0]   stop;
        logic [63:0]   at;
        logic [63:0]   nxt;
        logic [63:0]   addr_mask;
        res = '{status: ST_IDLE, opcode: OP_NONE, addr: '0, last: 1'b0};
        // A unit size of zero behaves as one byte.
        sec = (sec_size == '0) ? 64'd1 : 64'(sec_size);
        blk = (blk_size == '0) ? 64'd1 : 64'(blk_size);
        dev = 64'(dev_size);
        base = 64'(first);
        addr_mask = (64'd1 << ADDR_WIDTH) - 64'd1;
        if (kind == KIND_START) begin
            // Any start drops the plan that was still pending.
            plan_live = 1'b0;
            if (span == '0) begin
                res.status = ST_EMPTY;
            end else if (base >= dev || 64'(span) > dev - base) begin
                res.status = ST_ERROR;
            end else begin
                stop = base + 64'(span);
                if ((stop % sec) != 0) begin
                    stop = stop + sec - (stop % sec);
                end
                if (stop > dev) begin
                    stop = dev;
                end
                walk_pos = PosW'(base - (base % sec));
                walk_end = PosW'(stop);
                plan_live = walk_pos < walk_end;
                res.status = ST_ACCEPT;
            end
        end else if (!plan_live || walk_pos >= walk_end) begin
            plan_live = 1'b0;
        end else begin
            // Block erase only where aligned and a whole block still fits.
            at = 64'(walk_pos);
            if ((at % blk) == 0 && 64'(walk_end) - at >= blk) begin
                res.opcode = OP_BLOCK;
                nxt = at + blk;
            end else begin
                res.opcode = OP_SECTOR;
                nxt = at + sec;
            end
            walk_pos = PosW'(nxt);
            res.last = (walk_pos >= walk_end) || (64'(walk_pos) <= at);
            plan_live = !res.last;
            res.status = ST_CMD;
            res.addr = AddrFieldW'(at & addr_mask);
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // Registers, accepted requests and accepted results, all seen at the rising edge.
    always @(posedge i_clk) begin
        t_erase_result want;
        if (!i_rst_n) begin
            sec_size = SEC_RESET;
            blk_size = BLK_RESET;
            dev_size = DEV_RESET;
            walk_pos = '0;
            walk_end = '0;
            plan_live = 1'b0;
            planned_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SECTOR: sec_size = i_cfg_data[UnitW-1:0];
                    CFG_BLOCK:  blk_size = i_cfg_data[UnitW-1:0];
                    CFG_DEVICE: dev_size = i_cfg_data[DevW-1:0];
                    default: ;
                endcase
            end
            // A result never belongs to the request taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (planned_results.size() == 0) begin
                    $error("result with no request outstanding: status 0x%0h", i_status);
                    o_fail_count++;
                end else begin
                    want = planned_results.pop_front();
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("erase_opcode", 64'(want.opcode), 64'(i_erase_opcode));
                    check_field("erase_addr", 64'(want.addr), 64'(i_erase_addr));
                    check_field("last", 64'(want.last), 64'(i_last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                planned_results.push_back(plan_next_result(i_kind, i_start_addr, i_length));
            end
        end
        o_open_count = planned_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Top-level testbench of the erase range planner: request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import erp_pkg::*;
    import erp_tb_pkg::*;

    localparam int ADDR_W        = 32;
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 800;
    localparam int PHASE_ITEMS   = 64;
    localparam int SETTLE_CYCLES = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CfgDataW-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_kind;
    logic [AddrFieldW-1:0] req_start;
    logic [AddrFieldW-1:0] req_length;
    logic                  out_valid;
    logic                  out_ready;
    t_status               rsp_status;
    t_opcode               rsp_opcode;
    logic [AddrFieldW-1:0] rsp_addr;
    logic                  rsp_last;
    int                    open_count;
    int                    fail_count;

    // Stimulus-side view of the sizes, used only to shape ranges.
    logic [63:0] sec_now;
    logic [63:0] blk_now;
    logic [63:0] dev_now;
    int          burst_left;
    int          items_sent;
    int          cycle_count;
    logic        hold_req;

    erase_range_planner_core #(
        .ADDR_WIDTH(ADDR_W)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (req_kind),
        .i_start_addr  (req_start),
        .i_length      (req_length),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (rsp_status),
        .o_erase_opcode(rsp_opcode),
        .o_erase_addr  (rsp_addr),
        .o_last        (rsp_last)
    );

    erase_plan_checker #(
        .ADDR_WIDTH(ADDR_W)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (req_kind),
        .i_start_addr  (req_start),
        .i_length      (req_length),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (rsp_status),
        .i_erase_opcode(rsp_opcode),
        .i_erase_addr  (rsp_addr),
        .i_last        (rsp_last),
        .o_open_count  (open_count),
        .o_fail_count  (fail_count)
    );

    always #5 clk = ~clk;

    // Offers one request; the sender runs in bursts with random gaps between them.
    task automatic send_request(input logic kind, input logic [31:0] first,
                                input logic [31:0] span);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(40, 90);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid   <= 1'b1;
        req_kind   <= kind;
        req_start  <= first;
        req_length <= span;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (open_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        case (idx)
            CFG_SECTOR: sec_now = (value[UnitW-1:0] == '0) ? 64'd1 : 64'(value[UnitW-1:0]);
            CFG_BLOCK:  blk_now = (value[UnitW-1:0] == '0) ? 64'd1 : 64'(value[UnitW-1:0]);
            CFG_DEVICE: dev_now = 64'(value);
            default: ;
        endcase
    endtask

    task automatic set_sizes(input logic [31:0] sec, input logic [31:0] blk,
                             input logic [31:0] dev, input logic junk_write);
        drain();
        write_reg(CFG_SECTOR, sec);
        write_reg(CFG_BLOCK, blk);
        write_reg(CFG_DEVICE, dev);
        if (junk_write) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_unit_raw();
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0:       v = 32'd1;
            1:       v = 32'h0100_0000;
            2:       v = 32'd0;
            3:       v = $urandom_range(1, 4096);
            4:       v = 32'd1 << $urandom_range(0, 24);
            default: v = $urandom_range(2, 64);
        endcase
        // Bits above the register width must be dropped by the block.
        if ($urandom_range(0, 3) == 0) begin
            v[31:UnitW] = 7'($urandom);
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_device_raw();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom;
            2:       return 32'd0;
            3:       return $urandom_range(1, 65536);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // A valid range followed by a run of next requests with random payload.
    task automatic send_plan();
        logic [63:0] reach;
        logic [63:0] first;
        logic [63:0] room;
        logic [63:0] span;
        int          nexts;
        if (dev_now == 0) begin
            send_request(KIND_START, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
            return;
        end
        reach = ($urandom_range(0, 1) == 0) ? 64'd6 * sec_now : 64'd3 * blk_now;
        case ($urandom_range(0, 3))
            0: first = 64'($urandom_range(0, 32'(dev_now - 1)));
            1: first = dev_now - 64'($urandom_range(1, 32'(min64(reach, dev_now))));
            2: begin
                first = 64'($urandom_range(0, 32'(dev_now - 1)));
                first = first - (first % blk_now);
            end
            default: first = 64'($urandom_range(0, 32'(min64(dev_now - 1, 64'd4 * blk_now))));
        endcase
        room = dev_now - first;
        if ($urandom_range(0, 7) == 0) begin
            span = min64(room, reach);
        end else begin
            span = 64'($urandom_range(1, 32'(min64(room, reach))));
        end
        send_request(KIND_START, 32'(first), 32'(span));
        nexts = $urandom_range(1, 12);
        repeat (nexts) send_request(KIND_NEXT, $urandom, $urandom);
    endtask

    // Malformed and odd requests: stray nexts, empty and out-of-range starts.
    task automatic send_noise();
        logic [31:0] first;
        case ($urandom_range(0, 5))
            0: send_request(KIND_NEXT, $urandom, $urandom);
            1: send_request(KIND_START, $urandom, 32'd0);
            2: send_request(KIND_START, $urandom, $urandom);
            3: send_request(KIND_START, 32'(dev_now), $urandom_range(1, 16));
            4: send_request(KIND_START, $urandom, 32'hFFFF_FFFF);
            default: begin
                first = (dev_now == 0) ? 32'd0 : $urandom_range(0, 32'(dev_now - 1));
                send_request(KIND_START, first,
                             32'(dev_now - 64'(first) + 64'($urandom_range(1, 16))));
            end
        endcase
    endtask

    // The receiver stalls on a changing pattern, and holds off long when asked.
    initial begin : receiver
        int pattern_left;
        int stall_mode;
        int hold_cnt;
        pattern_left = 0;
        stall_mode = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
                hold_req = 1'b0;
            end
            if (pattern_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Hard stop for a hung run.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) @(posedge clk) cycle_count++;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_base;
        int random_base;
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_SECTOR;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_kind   = KIND_START;
        req_start  = '0;
        req_length = '0;
        out_ready  = 1'b0;
        hold_req   = 1'b0;
        burst_left = 0;
        items_sent = 0;
        sec_now    = 64'(SEC_RESET);
        blk_now    = 64'(BLK_RESET);
        dev_now    = 64'(DEV_RESET);
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the sizes left at their reset values.
        send_request(KIND_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_START, 32'hFFFF_FFFF, 32'd0);
        send_request(KIND_START, 32'h0100_0000, 32'd1);
        send_request(KIND_START, 32'hFFFF_FFFF, 32'd1);
        send_request(KIND_START, 32'd0, 32'h0100_0001);
        send_request(KIND_START, 32'h0000_0010, 32'hFFFF_FFFF);
        // Unaligned range across a block boundary: two sector erases.
        send_request(KIND_START, 32'h0000_FFF0, 32'h0000_0020);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        // Block-aligned range, replaced by a new start before it finishes.
        send_request(KIND_START, 32'h0002_0000, 32'h0001_0001);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_START, 32'h00FF_FFFF, 32'd1);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        // Whole device, cut short by an empty start.
        send_request(KIND_START, 32'd0, 32'h0100_0000);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_START, 32'h0000_5000, 32'd0);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        // Aligned to a block but shorter than one: sector erases only.
        send_request(KIND_START, 32'h0003_0000, 32'h0000_8000);
        send_request(KIND_NEXT, 32'd0, 32'd0);
        send_request(KIND_NEXT, 32'd0, 32'd0);

        // Random part, one size setting per phase, each written while idle.
        random_base = items_sent;
        phase = 0;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            case (phase)
                0:       set_sizes(32'd1, 32'd1, 32'd1, 1'b0);
                1:       set_sizes(32'd0, 32'd0, 32'd50, 1'b0);
                2:       set_sizes(32'h0100_0000, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0);
                3:       set_sizes(32'd4, 32'd16, 32'd0, 1'b0);
                4:       set_sizes(32'hFE00_0003, 32'd10, 32'd100, 1'b1);
                5:       set_sizes(32'd64, 32'd16, 32'd1000, 1'b0);
                default: set_sizes(pick_unit_raw(), pick_unit_raw(), pick_device_raw(),
                                   $urandom_range(0, 5) == 0);
            endcase
            // Long receiver hold-off so the block backs up onto its input.
            if (phase == 0 || $urandom_range(0, 7) == 0) begin
                hold_req = 1'b1;
            end
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_plan();
                end else begin
                    send_noise();
                end
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
